### hdl/ajbfc_pkg.sv
// Shared types, codes and defaults for the audio jitter buffer flow control block.
package ajbfc_pkg;

   localparam int RING_SLOTS_DEFAULT = 32;

   localparam int CFG_W       = 5;
   localparam int CSR_ADDR_W  = 2;
   localparam int BYTES_W     = 16;
   localparam int SLOT_W      = 5;
   localparam int TOTAL_W     = 32;

   localparam logic [CFG_W-1:0] START_LEVEL_RESET       = 5'd2;
   localparam logic [CFG_W-1:0] OVERFLOW_LEVEL_RESET    = 5'd14;
   localparam logic [CFG_W-1:0] DROP_AMOUNT_RESET       = 5'd6;
   localparam logic [CFG_W-1:0] DROP_CANCEL_LEVEL_RESET = 5'd4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_LEVEL       = 2'd0,
      CSR_OVERFLOW_LEVEL    = 2'd1,
      CSR_DROP_AMOUNT       = 2'd2,
      CSR_DROP_CANCEL_LEVEL = 2'd3
   } csr_addr_type;

   typedef enum logic {
      ACT_SUBMIT = 1'b0,
      ACT_DONE   = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_QUEUED       = 3'd0,
      ST_DROPPED      = 3'd1,
      ST_SLOT_BUSY    = 3'd2,
      ST_COMPLETED    = 3'd3,
      ST_COMPLETED_OO = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_PAUSE   = 2'd2
   } play_cmd_type;

   typedef struct packed {
      logic [CFG_W-1:0] start_level;
      logic [CFG_W-1:0] overflow_level;
      logic [CFG_W-1:0] drop_amount;
      logic [CFG_W-1:0] drop_cancel_level;
   } cfg_type;

   typedef struct packed {
      action_type         action;
      logic [BYTES_W-1:0] chunk_bytes;
      logic [SLOT_W-1:0]  done_slot;
   } event_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      play_cmd_type       play_command;
      logic               drop_finished;
      logic [TOTAL_W-1:0] dropped_bytes;
      logic [SLOT_W-1:0]  buffers_in_use;
      logic [SLOT_W-1:0]  expected_slot;
   } result_type;

endpackage

### hdl/ajbfc_engine.sv
// Ring state and combinational event evaluation for the audio buffer flow control.
module ajbfc_engine
   import ajbfc_pkg::*;
#(
   parameter int RING_SLOTS = RING_SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  event_type  evt,
   input  cfg_type    cfg,
   output result_type rslt
);

   localparam int PTR_W = $clog2(RING_SLOTS);
   localparam int CMP_W = (PTR_W > CFG_W) ? PTR_W : CFG_W;
   localparam int RNG_W = $clog2(RING_SLOTS + 1) + SLOT_W;

   logic [RING_SLOTS-1:0] busy_ff, busy_in;
   logic [PTR_W-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic                  playing_ff, playing_in;
   logic [CFG_W-1:0]      drops_left_ff, drops_left_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;

   logic [PTR_W-1:0]      wp_nxt, rp_nxt, inuse, done_idx;
   logic [CMP_W-1:0]      inuse_c;
   logic                  done_in_ring;
   logic [CFG_W-1:0]      dl_dec;
   logic [TOTAL_W-1:0]    total_sum;

   assign wp_nxt = (wp_ff == PTR_W'(RING_SLOTS - 1)) ? '0 : wp_ff + PTR_W'(1);
   assign rp_nxt = (rp_ff == PTR_W'(RING_SLOTS - 1)) ? '0 : rp_ff + PTR_W'(1);
   assign inuse  = (wp_ff >= rp_ff) ? (wp_ff - rp_ff)
                                    : (wp_ff - rp_ff + PTR_W'(RING_SLOTS));
   assign inuse_c      = CMP_W'(inuse);
   assign done_idx     = PTR_W'(evt.done_slot);
   assign done_in_ring = RNG_W'(evt.done_slot) < RNG_W'(RING_SLOTS);
   assign dl_dec       = drops_left_ff - CFG_W'(1);
   assign total_sum    = total_ff + TOTAL_W'(evt.chunk_bytes);

   always_comb begin
      busy_in       = busy_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      playing_in    = playing_ff;
      drops_left_in = drops_left_ff;
      total_in      = total_ff;

      rslt                = '0;
      rslt.status         = ST_QUEUED;
      rslt.play_command   = CMD_NONE;
      rslt.slot           = SLOT_W'(wp_ff);
      rslt.buffers_in_use = SLOT_W'(inuse);
      rslt.expected_slot  = SLOT_W'(rp_ff);

      if (evt.action == ACT_DONE) begin
         rslt.slot   = evt.done_slot;
         rslt.status = ST_COMPLETED_OO;
         if (done_in_ring) begin
            busy_in[done_idx] = 1'b0;
            if (done_idx == rp_ff) begin
               rp_in       = rp_nxt;
               rslt.status = ST_COMPLETED;
            end
         end
      end else if (busy_ff[wp_ff]) begin
         rslt.status = ST_SLOT_BUSY;
      end else if (drops_left_ff != '0) begin
         // discard the chunk; end the run when used up or the queue runs low
         rslt.status = ST_DROPPED;
         total_in    = total_sum;
         if (inuse_c < CMP_W'(cfg.drop_cancel_level) || dl_dec == '0) begin
            drops_left_in      = '0;
            rslt.drop_finished = 1'b1;
            rslt.dropped_bytes = total_sum;
         end else begin
            drops_left_in = dl_dec;
         end
      end else begin
         if (inuse == '0) begin
            playing_in        = 1'b0;
            rslt.play_command = CMD_PAUSE;
         end else if (!playing_ff) begin
            if (inuse_c >= CMP_W'(cfg.start_level)) begin
               playing_in        = 1'b1;
               rslt.play_command = CMD_RESTART;
            end
         end else if (inuse_c >= CMP_W'(cfg.overflow_level)) begin
            drops_left_in = cfg.drop_amount;
            total_in      = '0;
         end
         busy_in[wp_ff] = 1'b1;
         wp_in          = wp_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= '0;
         wp_ff         <= '0;
         rp_ff         <= '0;
         playing_ff    <= 1'b0;
         drops_left_ff <= '0;
         total_ff      <= '0;
      end else if (fire) begin
         busy_ff       <= busy_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         playing_ff    <= playing_in;
         drops_left_ff <= drops_left_in;
         total_ff      <= total_in;
      end
   end

   // write pointer moves only for a queued chunk
   a_wp_only_on_queue: assert property (@(posedge clock) disable iff (reset)
      !(fire && rslt.status == ST_QUEUED) |=> $stable(wp_ff))
      else $error("write pointer moved without a queued chunk");

   // read pointer moves only for an in-order completion
   a_rp_only_on_complete: assert property (@(posedge clock) disable iff (reset)
      !(fire && rslt.status == ST_COMPLETED) |=> $stable(rp_ff))
      else $error("read pointer moved without an in-order completion");

   a_finish_is_drop: assert property (@(posedge clock) disable iff (reset)
      rslt.drop_finished |-> rslt.status == ST_DROPPED)
      else $error("drop finish flagged on a non-dropped event");

   a_finish_clears_run: assert property (@(posedge clock) disable iff (reset)
      fire && rslt.drop_finished |=> drops_left_ff == '0)
      else $error("drop run still pending after it finished");

endmodule

### hdl/audio_jitter_buffer_flow_control_top.sv
// Top level of the audio jitter buffer flow control: stream ports, settings and pipeline.
//
// Flow control for a ring of audio output buffers, one result per event.
// Input stream req_*: tuser carries the action (submit a chunk or a buffer
// finished playing), tdata the chunk byte count and the finished slot.
// Result stream rsp_*: tuser carries the status, tdata the slot, playback
// command, drop-run end flag and byte total, queue occupancy and read pointer.
// Settings are written on csr_* (index 0 start level, 1 overflow level,
// 2 drop amount, 3 drop cancel level); the user must write them only while
// no transaction is in flight, as the block itself does not enforce it.
// A transaction passes the input register, then evaluation into the result register.
// Throughput: one transaction per cycle unless rsp_* stalls; ring state is read
// and updated by the evaluation stage in the same cycle, so back-to-back events chain.
// When rsp_tready is low the result register holds, the input register
// fills, and req_tready drops until the result is taken.
// Synchronous reset empties the ring, clears pointers, playback and drop
// state, and restores the default settings; no clearing pass is needed.
module audio_jitter_buffer_flow_control_top
   import ajbfc_pkg::*;
#(
   parameter int RING_SLOTS = RING_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // chunk_bytes[15:0], done_slot[20:16], zero pad
   input  logic [0:0]            req_tuser,  // action[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slot[4:0], play_command[6:5], drop_finished[7], dropped_bytes[39:8],
   // buffers_in_use[44:40], expected_slot[49:45], zero pad
   output logic [55:0]           rsp_tdata,
   output logic [2:0]            rsp_tuser,  // status[2:0]
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   cfg_type    cfg_ff;
   logic       s1_valid_ff;
   event_type  s1_evt_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type rslt;
   event_type  req_evt;
   logic       out_free, fire, req_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign req_evt.action      = action_type'(req_tuser[0]);
   assign req_evt.chunk_bytes = req_tdata[15:0];
   assign req_evt.done_slot   = req_tdata[20:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_level       <= START_LEVEL_RESET;
         cfg_ff.overflow_level    <= OVERFLOW_LEVEL_RESET;
         cfg_ff.drop_amount       <= DROP_AMOUNT_RESET;
         cfg_ff.drop_cancel_level <= DROP_CANCEL_LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_addr_type'(csr_addr))
            CSR_START_LEVEL:       cfg_ff.start_level       <= csr_wdata;
            CSR_OVERFLOW_LEVEL:    cfg_ff.overflow_level    <= csr_wdata;
            CSR_DROP_AMOUNT:       cfg_ff.drop_amount       <= csr_wdata;
            CSR_DROP_CANCEL_LEVEL: cfg_ff.drop_cancel_level <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register: load on a new transaction, empty when evaluated
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_evt_ff <= req_evt;
      end
   end

   ajbfc_engine #(
      .RING_SLOTS(RING_SLOTS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .fire (fire),
      .evt  (s1_evt_ff),
      .cfg  (cfg_ff),
      .rslt (rslt)
   );

   // result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rslt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {6'd0,
                        rsp_data_ff.expected_slot,
                        rsp_data_ff.buffers_in_use,
                        rsp_data_ff.dropped_bytes,
                        rsp_data_ff.drop_finished,
                        rsp_data_ff.play_command,
                        rsp_data_ff.slot};

endmodule
